// ===== src/esk_pkg.sv =====
package esk_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int KEY_BITS    = 12;

    localparam int KEY_FIELD_W = 12;
    localparam int TAG_W       = 6;
    // stored key width: low KEY_BITS bits of the key field
    localparam int KEY_W       = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    typedef struct packed {
        logic [KEY_FIELD_W-1:0] sort_key;
        logic [TAG_W-1:0]       record_tag;
        logic                   last_item;
    } t_in_item;

    typedef struct packed {
        logic [KEY_FIELD_W-1:0] out_key;
        logic [TAG_W-1:0]       out_tag;
        logic                   group_start;
        logic                   overflow;
        logic                   last_out;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

endpackage

// ===== src/esk_ram.sv =====
module esk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/exchange_sort_by_key_core.sv =====
// Collects up to MAX_RECORDS records (key and tag) at one per cycle until a
// transaction marked last, then sorts them ascending by key with an exchange
// sort and sends them out in order. The sort works through the single read
// port of the record RAM feeding one key comparator: each compare-and-swap
// against the held record costs one RAM read. Each position is sent as soon
// as its scan finishes; a stalled output holds the sequencer. Records beyond
// capacity are dropped and every result of that set carries the overflow
// flag. The input stalls from the last record of a set until its final
// result has been loaded into the output register.
module exchange_sort_by_key_core
    import esk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_HEAD = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_drop, n_drop;
    logic [IDX_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_rd, n_rd;
    logic             r_head_pend, n_head_pend;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0] r_cmp_addr, n_cmp_addr;
    t_rec             r_cur, n_cur;
    logic [KEY_W-1:0] r_prev, n_prev;
    logic             r_ovld, n_ovld;
    t_out_item        r_out, n_out;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_rec             ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    t_rec             ram_rdata;

    logic             in_take;
    logic             out_free;
    logic             issue;
    logic             set_done;

    esk_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (MAX_RECORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_take  = i_in_valid && (r_state == S_LOAD);
    assign out_free = !r_ovld || !i_out_stall;
    assign issue    = r_rd < r_cnt;
    assign set_done = (CNT_W'(r_i) + CNT_W'(1)) == r_cnt;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_drop      = r_drop;
        n_i         = r_i;
        n_rd        = r_rd;
        n_head_pend = r_head_pend;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_addr  = r_cmp_addr;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_ovld      = r_ovld && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt[IDX_W-1:0];
        ram_wdata   = r_cur;
        ram_re      = 1'b0;
        ram_raddr   = r_i;

        case (r_state)
            S_LOAD: begin
                if (in_take) begin
                    if (r_cnt < CNT_W'(MAX_RECORDS)) begin
                        ram_we        = 1'b1;
                        ram_waddr     = r_cnt[IDX_W-1:0];
                        ram_wdata.key = KEY_W'(i_in_data.sort_key);
                        ram_wdata.tag = i_in_data.record_tag;
                        n_cnt         = r_cnt + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in_data.last_item) begin
                        n_i     = '0;
                        n_state = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                ram_re      = 1'b1;
                ram_raddr   = r_i;
                n_rd        = CNT_W'(r_i) + CNT_W'(1);
                n_head_pend = 1'b1;
                n_cmp_vld   = 1'b0;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                // data stage: record read last cycle
                if (r_head_pend) begin
                    n_cur = ram_rdata;
                end else if (r_cmp_vld && (r_cur.key > ram_rdata.key)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cmp_addr;
                    ram_wdata = r_cur;
                    n_cur     = ram_rdata;
                end
                // read stage: next later position
                n_head_pend = 1'b0;
                n_cmp_vld   = issue;
                n_cmp_addr  = r_rd[IDX_W-1:0];
                if (issue) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rd[IDX_W-1:0];
                    n_rd      = r_rd + CNT_W'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // r_cur now holds the final record of position r_i
                if (out_free) begin
                    n_ovld            = 1'b1;
                    n_out.out_key     = KEY_FIELD_W'(r_cur.key);
                    n_out.out_tag     = r_cur.tag;
                    n_out.group_start = (r_i == '0) || (r_cur.key != r_prev);
                    n_out.overflow    = r_drop;
                    n_out.last_out    = set_done;
                    n_prev            = r_cur.key;
                    if (set_done) begin
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_i     = r_i + IDX_W'(1);
                        n_state = S_HEAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_i         <= '0;
            r_rd        <= '0;
            r_head_pend <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_prev      <= '0;
            r_ovld      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_drop      <= n_drop;
            r_i         <= n_i;
            r_rd        <= n_rd;
            r_head_pend <= n_head_pend;
            r_cmp_vld   <= n_cmp_vld;
            r_prev      <= n_prev;
            r_ovld      <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_addr <= n_cmp_addr;
        r_cur      <= n_cur;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import esk_pkg::*;

    typedef struct {
        t_in_item rec;
        bit       drain;    // hold this record until all sorted output has come back
    } t_feed;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} t_stall_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    exchange_sort_by_key_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #4 clk = ~clk;

    t_feed     record_feed_q[$];
    t_out_item sorted_records_q[$];
    int        err_count = 0;

    // shadow of the record store
    logic [KEY_W-1:0] key_mem [MAX_RECORDS];
    logic [TAG_W-1:0] tag_mem [MAX_RECORDS];
    int               rec_count   = 0;
    bit               set_dropped = 1'b0;
    logic [KEY_W-1:0] last_emitted = '0;

    task automatic flag_error(input string msg);
        $display("tb: mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    // stores one record; on the last record of a set, sorts and queues the output
    task automatic take_record(input t_in_item it);
        logic [KEY_W-1:0] kt;
        logic [TAG_W-1:0] tt;
        t_out_item        r;
        if (rec_count < MAX_RECORDS) begin
            key_mem[rec_count] = it.sort_key[KEY_W-1:0];
            tag_mem[rec_count] = it.record_tag;
            rec_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!it.last_item)
            return;
        for (int i = 0; i < rec_count; i++) begin
            for (int j = i + 1; j < rec_count; j++) begin
                if (key_mem[i] > key_mem[j]) begin
                    kt = key_mem[i]; key_mem[i] = key_mem[j]; key_mem[j] = kt;
                    tt = tag_mem[i]; tag_mem[i] = tag_mem[j]; tag_mem[j] = tt;
                end
            end
        end
        for (int k = 0; k < rec_count; k++) begin
            r = '0;
            r.out_key[KEY_W-1:0] = key_mem[k];
            r.out_tag     = tag_mem[k];
            r.group_start = (k == 0) || (key_mem[k] != last_emitted);
            r.overflow    = set_dropped;
            r.last_out    = (k == rec_count - 1);
            last_emitted  = key_mem[k];
            sorted_records_q.push_back(r);
        end
        rec_count   = 0;
        set_dropped = 1'b0;
    endtask

    task automatic queue_record(input logic [11:0] k, input logic [5:0] t, input bit last,
                                input bit drain);
        t_feed f;
        f.rec.sort_key   = k;
        f.rec.record_tag = t;
        f.rec.last_item  = last;
        f.drain          = drain;
        record_feed_q.push_back(f);
    endtask

    // sampling at the rising edge
    bit in_took = 1'b0;
    t_out_item want;

    always @(posedge clk) begin
        in_took = rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall) begin
            if (sorted_records_q.size() == 0) begin
                flag_error($sformatf("unexpected result key %0d tag %0d",
                                     out_data.out_key, out_data.out_tag));
            end else begin
                want = sorted_records_q.pop_front();
                if (out_data.out_key != want.out_key)
                    flag_error($sformatf("out_key got %0d want %0d",
                                         out_data.out_key, want.out_key));
                if (out_data.out_tag != want.out_tag)
                    flag_error($sformatf("out_tag got %0d want %0d (key %0d)",
                                         out_data.out_tag, want.out_tag, want.out_key));
                if (out_data.group_start != want.group_start)
                    flag_error($sformatf("group_start got %0b want %0b (key %0d)",
                                         out_data.group_start, want.group_start, want.out_key));
                if (out_data.overflow != want.overflow)
                    flag_error($sformatf("overflow got %0b want %0b (key %0d)",
                                         out_data.overflow, want.overflow, want.out_key));
                if (out_data.last_out != want.last_out)
                    flag_error($sformatf("last_out got %0b want %0b (key %0d)",
                                         out_data.last_out, want.last_out, want.out_key));
            end
        end
        if (in_took)
            take_record(in_data);
    end

    // sender: bursts with random gaps, driven at the falling edge
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_took) begin
            // stalled transaction holds
        end else if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left--;
        end else if (record_feed_q.size() != 0 &&
                     !(record_feed_q[0].drain && sorted_records_q.size() != 0)) begin
            in_data  <= record_feed_q[0].rec;
            in_valid <= 1'b1;
            void'(record_feed_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern switches between randomly chosen modes
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          phase      = 0;

    always @(negedge clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        phase++;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_RANDOM:   out_stall <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: out_stall <= (phase % 3 == 0);
            default:        out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    initial begin
        int          total;
        int          len;
        int          setn;
        logic [11:0] k;

        // single record set at the bottom extreme
        queue_record(12'h000, 6'h00, 1'b1, 1'b0);
        // extremes and a tie at the top key
        queue_record(12'hFFF, 6'h3F, 1'b0, 1'b0);
        queue_record(12'h000, 6'h01, 1'b0, 1'b0);
        queue_record(12'hFFF, 6'h02, 1'b0, 1'b0);
        queue_record(12'h800, 6'h2A, 1'b1, 1'b0);
        // next set opens with the key that closed the last one: still a new group
        queue_record(12'hFFF, 6'h05, 1'b0, 1'b0);
        queue_record(12'hFFF, 6'h06, 1'b1, 1'b0);
        // equal keys after a larger one; the exchange procedure leaves them in input order here
        queue_record(12'd5, 6'h07, 1'b0, 1'b0);
        queue_record(12'd3, 6'h08, 1'b0, 1'b0);
        queue_record(12'd3, 6'h09, 1'b1, 1'b0);
        // strictly descending
        for (int n = 0; n < 5; n++)
            queue_record(12'(10 - n), 6'(n), n == 4, 1'b0);
        // alternating bit patterns
        queue_record(12'hAAA, 6'h15, 1'b0, 1'b0);
        queue_record(12'h555, 6'h2A, 1'b1, 1'b0);
        total = 17;

        // random sets, mostly small; one exactly full, one past capacity
        setn = 0;
        while (total < 197) begin
            case (setn)
                3:       len = MAX_RECORDS;
                8:       len = MAX_RECORDS + $urandom_range(1, 5);
                default: len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                           : $urandom_range(1, 8);
            endcase
            for (int n = 0; n < len; n++) begin
                case ($urandom_range(0, 5))
                    0:       k = 12'($urandom_range(0, 7));
                    1:       k = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                    default: k = 12'($urandom_range(0, 4095));
                endcase
                queue_record(k, 6'($urandom_range(0, 63)), n == len - 1,
                             n == 0 && (setn == 4 || setn == 9 || setn == 14));
            end
            total += len;
            setn++;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (record_feed_q.size() != 0 || in_valid)
            @(posedge clk);
        while (sorted_records_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/esk_pkg.sv
src/esk_ram.sv
src/exchange_sort_by_key_core.sv
bench/tb.sv
